FILE: rtl/core/txc_pkg.sv
// Package for the text console writer: word types, kind codes and character codes.
// Has no dependencies. The other files reach it through scoped names.
`default_nettype none

package txc_pkg;

  localparam int KIND_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int IN_ROW_W = 5;
  localparam int IN_COL_W = 7;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CHR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHR_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
  localparam logic [CELL_W-1:0] CELL_RESET  = {ATTR_RESET, CHR_BLANK};

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   char_code;
    logic [IN_ROW_W-1:0] row;
    logic [IN_COL_W-1:0] col;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]    cursor_pos;
    logic [IN_ROW_W-1:0] cursor_row;
    logic [IN_COL_W-1:0] cursor_col;
    logic [CELL_W-1:0]   cell_data;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/core/text_console_writer_unit.sv
// Text console writer top level: cell memory, cursor and the sequencer around them.
// Depends on txc_pkg.
//
// A text console of ROWS x COLUMNS cells, each holding an attribute byte above a character
// byte, plus a cursor. The cells live in one memory with one write port and one read port
// and a registered read. After reset the block sweeps the memory to blanks with attribute
// 0x0F, one cell per cycle, and input words are refused until the sweep is done. The
// attribute register can be written at any time, including during that sweep. A word is
// worked one at a time: set cursor, cell read and a put character that does not scroll
// pass through the execute and response states, and the result is loaded in the response
// state once the output register is free. A scroll moves the lines up, one cell per cycle
// through the memory's read and write ports, then blanks the bottom line. Clear screen
// blanks every cell and homes the cursor. A result waits in an output register, and the
// next input word is accepted while it waits.
`default_nettype none

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire txc_pkg::in_t                 in_word_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output txc_pkg::out_t                     out_word_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [txc_pkg::ATTR_W-1:0]   cfg_data_i
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int MOVE_N = (ROWS - 1) * COLUMNS;
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int AW     = $clog2(CELLS);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  function automatic logic [AW-1:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * 32'(COLUMNS) + 32'(c));
  endfunction

  logic [2:0]                      state_q, state_d;
  logic [RW-1:0]                   row_q, row_d;
  logic [CW-1:0]                   col_q, col_d;
  logic [AW-1:0]                   ptr_q, ptr_d;
  logic                            mv_pend_q, mv_pend_d;
  logic [AW-1:0]                   mv_addr_q, mv_addr_d;
  logic [txc_pkg::ATTR_W-1:0]      attr_q;
  logic                            out_valid_q;
  txc_pkg::out_t                   out_q;
  logic                            out_load;

  logic [txc_pkg::KIND_W-1:0]      kind_q;
  logic [txc_pkg::CHAR_W-1:0]      char_q;
  logic [RW-1:0]                   trow_q;
  logic [CW-1:0]                   tcol_q;
  logic [RW-1:0]                   in_row_c;
  logic [CW-1:0]                   in_col_c;

  logic [txc_pkg::CELL_W-1:0]      mem [CELLS];
  logic [txc_pkg::CELL_W-1:0]      mem_rdata_q;
  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic [txc_pkg::CELL_W-1:0]      mem_wdata;

  logic [CW:0]                     tab_sum, tab_col, col_inc;
  logic                            row_last, adv_row;
  logic                            in_fire;
  txc_pkg::out_t                   out_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign in_row_c = (32'(in_word_i.row) > 32'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(in_word_i.row);
  assign in_col_c = (32'(in_word_i.col) > 32'(COLUMNS - 1)) ? CW'(COLUMNS - 1)
                                                             : CW'(in_word_i.col);

  assign tab_sum  = (CW + 1)'(col_q) + (CW + 1)'(8);
  assign tab_col  = tab_sum & ~(CW + 1)'(7);
  assign col_inc  = (CW + 1)'(col_q) + (CW + 1)'(1);
  assign row_last = (row_q == RW'(ROWS - 1));

  always_comb begin
    out_d.cursor_pos = txc_pkg::POS_W'(lin(row_q, col_q));
    out_d.cursor_row = txc_pkg::IN_ROW_W'(row_q);
    out_d.cursor_col = txc_pkg::IN_COL_W'(col_q);
    out_d.cell_data  = (kind_q == txc_pkg::KIND_READ) ? mem_rdata_q : '0;
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    ptr_d     = ptr_q;
    mv_pend_d = 1'b0;
    mv_addr_d = mv_addr_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    adv_row   = 1'b0;
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = txc_pkg::CELL_RESET;
        if (ptr_q == AW'(CELLS - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESP;
        case (kind_q)
          txc_pkg::KIND_PUT: begin
            case (char_q)
              txc_pkg::CHR_NL: begin
                col_d   = '0;
                adv_row = 1'b1;
              end
              txc_pkg::CHR_CR: begin
                col_d = '0;
              end
              txc_pkg::CHR_TAB: begin
                if (32'(tab_col) >= 32'(COLUMNS)) begin
                  col_d   = '0;
                  adv_row = 1'b1;
                end else begin
                  col_d = CW'(tab_col);
                end
              end
              txc_pkg::CHR_BS: begin
                if (col_q != '0) begin
                  col_d     = col_q - CW'(1);
                  mem_we    = 1'b1;
                  mem_waddr = lin(row_q, col_q - CW'(1));
                  mem_wdata = {attr_q, txc_pkg::CHR_BLANK};
                end
              end
              default: begin
                mem_we    = 1'b1;
                mem_waddr = lin(row_q, col_q);
                mem_wdata = {attr_q, char_q};
                if (32'(col_inc) >= 32'(COLUMNS)) begin
                  col_d   = '0;
                  adv_row = 1'b1;
                end else begin
                  col_d = CW'(col_inc);
                end
              end
            endcase
            if (adv_row) begin
              if (row_last) begin
                ptr_d   = '0;
                state_d = ST_SCROLL;
              end else begin
                row_d = row_q + RW'(1);
              end
            end
          end
          txc_pkg::KIND_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            ptr_d   = '0;
            state_d = ST_FILL;
          end
          txc_pkg::KIND_SET: begin
            row_d = trow_q;
            col_d = tcol_q;
          end
          default: begin
            mem_re    = 1'b1;
            mem_raddr = lin(trow_q, tcol_q);
          end
        endcase
      end
      ST_SCROLL: begin
        // read line n+1 cell, write it back one line up on the next cycle
        if (mv_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = mv_addr_q;
          mem_wdata = mem_rdata_q;
        end
        if (ptr_q != AW'(MOVE_N)) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(COLUMNS);
          mv_pend_d = 1'b1;
          mv_addr_d = ptr_q;
          ptr_d     = ptr_q + AW'(1);
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = {attr_q, txc_pkg::CHR_BLANK};
        if (ptr_q == AW'(CELLS - 1)) begin
          ptr_d   = '0;
          state_d = ST_RESP;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      mv_pend_q   <= 1'b0;
      attr_q      <= txc_pkg::ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      ptr_q     <= ptr_d;
      mv_pend_q <= mv_pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mv_addr_q <= mv_addr_d;
    if (in_fire) begin
      kind_q <= in_word_i.kind;
      char_q <= in_word_i.char_code;
      trow_q <= in_row_c;
      tcol_q <= in_col_c;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // cell memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) <= 32'(ROWS - 1)) && (32'(col_q) <= 32'(COLUMNS - 1)))
    else $error("cursor out of range");

  a_no_addr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same cell in one cycle");

  a_quiet_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |-> !mem_we)
    else $error("memory write outside of work");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted word not executed");

endmodule

`default_nettype wire
